### src/rv32i_subset_instruction_decoder_defines.svh
// Assertion macros for the RV32I subset instruction decoder.
// Depends on nothing; included by the decoder top level, which carries the assertions.
`ifndef RV32I_SUBSET_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32I_SUBSET_INSTRUCTION_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define RVD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RVD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define RVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### src/rvd_pkg.sv
// Types and constants for the RV32I subset instruction decoder.
// Depends on nothing; imported by the decoder top level.
package rvd_pkg;

   // Major opcodes of the covered instruction classes.
   localparam logic [6:0] OPC_R    = 7'b0110011;
   localparam logic [6:0] OPC_S    = 7'b0100011;
   localparam logic [6:0] OPC_B    = 7'b1100011;
   localparam logic [6:0] OPC_JALR = 7'b1100111;
   localparam logic [6:0] OPC_LOAD = 7'b0000011;
   localparam logic [6:0] OPC_IMM  = 7'b0010011;
   localparam logic [6:0] OPC_JAL  = 7'b1101111;

   // funct7 values for R-type instructions.
   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // funct3 values used by the decoder.
   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SLL = 3'd1;
   localparam logic [2:0] F3_SLT = 3'd2;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_SRL = 3'd5;
   localparam logic [2:0] F3_OR  = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;
   localparam logic [2:0] F3_BEQ = 3'd0;
   localparam logic [2:0] F3_BNE = 3'd1;
   localparam logic [2:0] F3_BLT = 3'd4;
   localparam logic [2:0] F3_BGE = 3'd5;
   localparam logic [2:0] F3_WORD = 3'd2;

   // Register numbers that mark pseudo-ops.
   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_RA   = 5'd1;

   // Reset value of the start address register.
   localparam logic [31:0] START_RESET = 32'd496;

   localparam int COUNT_W = 30;
   localparam int IMM_W   = 21;

   // Mnemonic codes reported in the kind field.
   typedef enum logic [4:0] {
      K_UNKNOWN = 5'd0,
      K_ADD     = 5'd1,
      K_SUB     = 5'd2,
      K_SLL     = 5'd3,
      K_SLT     = 5'd4,
      K_XOR     = 5'd5,
      K_SRL     = 5'd6,
      K_OR      = 5'd7,
      K_AND     = 5'd8,
      K_SW      = 5'd9,
      K_BEQ     = 5'd10,
      K_BNE     = 5'd11,
      K_BLT     = 5'd12,
      K_BGE     = 5'd13,
      K_JALR    = 5'd14,
      K_RET     = 5'd15,
      K_LW      = 5'd16,
      K_ADDI    = 5'd17,
      K_NOP     = 5'd18,
      K_SLTI    = 5'd19,
      K_JAL     = 5'd20,
      K_J       = 5'd21
   } kind_type;

endpackage

### src/rv32i_subset_instruction_decoder.sv
// RV32I subset instruction decoder, top level.
// Depends on rvd_pkg and rv32i_subset_instruction_decoder_defines.svh.
//
// Usage:
// - The request channel (req_valid, req_stall, req_instruction_word) takes one
//   32-bit word per cycle. A word is taken when req_valid is high and
//   req_stall is low.
// - The response channel (rsp_valid, rsp_stall, rsp_*) gives one decoded
//   word per request: address, mnemonic code, register fields, immediate,
//   and the data flag with the signed data value.
// - The word enters an input register, is decoded in one pass, and lands in
//   the response register; throughput is one word per cycle unless the
//   receiver stalls, set by the single decode pass between the registers.
// - When the receiver stalls, the response register holds and the input
//   register can still take one more word; req_stall rises only when both
//   are full.
// - csr_wr_en with csr_wr_data writes the start address; write it only
//   while the block is idle. It does not clear the word count.
// - Synchronous reset empties both registers, clears the word count and the
//   data mode flag, and sets the start address to 496.
`include "rv32i_subset_instruction_decoder_defines.svh"

module rv32i_subset_instruction_decoder
   import rvd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_instruction_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_address,
   output logic [4:0]         rsp_kind,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic signed [20:0] rsp_immediate,
   output logic               rsp_is_data,
   output logic signed [31:0] rsp_data_value,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   // Input register and its valid flag.
   logic        in_valid_ff;
   logic [31:0] in_word_ff;

   // Block state: start address, word count, data mode.
   logic [31:0]        start_addr_ff;
   logic [COUNT_W-1:0] word_count_ff;
   logic               data_mode_ff;

   // Response register.
   logic               out_valid_ff;
   logic [31:0]        out_address_ff;
   kind_type           out_kind_ff;
   logic [4:0]         out_rd_ff;
   logic [4:0]         out_rs1_ff;
   logic [4:0]         out_rs2_ff;
   logic [IMM_W-1:0]   out_imm_ff;
   logic               out_is_data_ff;
   logic [31:0]        out_data_ff;

   // Decode results.
   kind_type           kind_in;
   logic [IMM_W-1:0]   imm_in;
   logic [31:0]        address_in;

   logic        advance;
   logic        accept;

   // Field views of the word in the input register.
   logic [6:0] opcode;
   logic [4:0] rd;
   logic [2:0] funct3;
   logic [4:0] rs1;
   logic [4:0] rs2;
   logic [6:0] funct7;
   logic [IMM_W-1:0] imm_i;
   logic [IMM_W-1:0] imm_s;
   logic [IMM_W-1:0] imm_b;
   logic [IMM_W-1:0] imm_j;

   // The word moves on when the response register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign opcode = in_word_ff[6:0];
   assign rd     = in_word_ff[11:7];
   assign funct3 = in_word_ff[14:12];
   assign rs1    = in_word_ff[19:15];
   assign rs2    = in_word_ff[24:20];
   assign funct7 = in_word_ff[31:25];

   // Immediates of the four formats, sign-extended to 21 bits.
   assign imm_i = {{9{in_word_ff[31]}}, in_word_ff[31:20]};
   assign imm_s = {{9{in_word_ff[31]}}, in_word_ff[31:25], in_word_ff[11:7]};
   assign imm_b = {{8{in_word_ff[31]}}, in_word_ff[31], in_word_ff[7],
                   in_word_ff[30:25], in_word_ff[11:8], 1'b0};
   assign imm_j = {in_word_ff[31], in_word_ff[19:12], in_word_ff[20],
                   in_word_ff[30:21], 1'b0};

   assign address_in = start_addr_ff + {word_count_ff, 2'b00};

   // Mnemonic and immediate selection by opcode and function fields.
   always_comb begin
      kind_in = K_UNKNOWN;
      imm_in  = '0;
      case (opcode)
         OPC_R: begin
            if (funct7 == F7_BASE) begin
               case (funct3)
                  F3_ADD:  kind_in = K_ADD;
                  F3_SLL:  kind_in = K_SLL;
                  F3_SLT:  kind_in = K_SLT;
                  F3_XOR:  kind_in = K_XOR;
                  F3_SRL:  kind_in = K_SRL;
                  F3_OR:   kind_in = K_OR;
                  F3_AND:  kind_in = K_AND;
                  default: kind_in = K_UNKNOWN;
               endcase
            end else if (funct7 == F7_ALT && funct3 == F3_ADD) begin
               kind_in = K_SUB;
            end
         end
         OPC_S: begin
            if (funct3 == F3_WORD) begin
               kind_in = K_SW;
               imm_in  = imm_s;
            end
         end
         OPC_B: begin
            case (funct3)
               F3_BEQ:  kind_in = K_BEQ;
               F3_BNE:  kind_in = K_BNE;
               F3_BLT:  kind_in = K_BLT;
               F3_BGE:  kind_in = K_BGE;
               default: kind_in = K_UNKNOWN;
            endcase
            if (kind_in != K_UNKNOWN) begin
               imm_in = imm_b;
            end
         end
         OPC_JALR: begin
            if (funct3 == F3_ADD) begin
               imm_in = imm_i;
               // A jump through ra with no offset and no link is a return.
               if (rd == REG_ZERO && rs1 == REG_RA && imm_i == '0) begin
                  kind_in = K_RET;
               end else begin
                  kind_in = K_JALR;
               end
            end
         end
         OPC_LOAD: begin
            if (funct3 == F3_WORD) begin
               kind_in = K_LW;
               imm_in  = imm_i;
            end
         end
         OPC_IMM: begin
            if (funct3 == F3_ADD) begin
               imm_in = imm_i;
               if (rd == REG_ZERO && rs1 == REG_ZERO && imm_i == '0) begin
                  kind_in = K_NOP;
               end else begin
                  kind_in = K_ADDI;
               end
            end else if (funct3 == F3_SLT) begin
               imm_in  = imm_i;
               kind_in = K_SLTI;
            end
         end
         OPC_JAL: begin
            imm_in  = imm_j;
            kind_in = (rd == REG_ZERO) ? K_J : K_JAL;
         end
         default: begin
            kind_in = K_UNKNOWN;
         end
      endcase
   end

   // Control state: valid flags, counter, mode flag, start address.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         word_count_ff <= '0;
         data_mode_ff  <= 1'b0;
         start_addr_ff <= START_RESET;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            word_count_ff <= word_count_ff + COUNT_W'(1);
            if (!data_mode_ff && kind_in == K_RET) begin
               data_mode_ff <= 1'b1;
            end
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            start_addr_ff <= csr_wr_data;
         end
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_instruction_word;
      end
   end

   // Response payload register; data mode blanks the decode fields.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_address_ff <= address_in;
         if (data_mode_ff) begin
            out_kind_ff    <= K_UNKNOWN;
            out_rd_ff      <= '0;
            out_rs1_ff     <= '0;
            out_rs2_ff     <= '0;
            out_imm_ff     <= '0;
            out_is_data_ff <= 1'b1;
            out_data_ff    <= in_word_ff;
         end else begin
            out_kind_ff    <= kind_in;
            out_rd_ff      <= rd;
            out_rs1_ff     <= rs1;
            out_rs2_ff     <= rs2;
            out_imm_ff     <= imm_in;
            out_is_data_ff <= 1'b0;
            out_data_ff    <= '0;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_address    = out_address_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_dest_reg   = out_rd_ff;
   assign rsp_src1_reg   = out_rs1_ff;
   assign rsp_src2_reg   = out_rs2_ff;
   assign rsp_immediate  = $signed(out_imm_ff);
   assign rsp_is_data    = out_is_data_ff;
   assign rsp_data_value = $signed(out_data_ff);

   // A data word never carries a mnemonic or an immediate.
   `RVD_ASSERT_SAME(a_data_blank, clock, reset, rsp_valid && rsp_is_data,
      rsp_kind == K_UNKNOWN && rsp_immediate == 21'sd0, "data word carries decode fields")
   // Every word moved to the response register counts once.
   `RVD_ASSERT_NEXT(a_count_step, clock, reset, advance,
      word_count_ff == ($past(word_count_ff) + 30'd1), "word count did not step")
   // A decoded return switches the block into data mode.
   `RVD_ASSERT_NEXT(a_ret_mode, clock, reset, advance && !data_mode_ff && kind_in == K_RET,
      data_mode_ff, "return did not enter data mode")
   // Data mode only leaves through reset.
   `RVD_ASSERT_NEXT(a_mode_sticky, clock, reset, data_mode_ff, data_mode_ff, "data mode cleared")

endmodule
